// ===== src/slsi_pkg.sv =====
`default_nettype none
package slsi_pkg;

	// Vector components, 33x33 products, cross products, |denominator|,
	// point numerator and its magnitude.
	localparam int VW = 33;
	localparam int PW = 66;
	localparam int CW = 67;
	localparam int DW = 66;
	localparam int NW = 100;
	localparam int MW = 99;

	localparam logic [1:0] ST_HIT      = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;
	localparam logic [1:0] ST_MISS     = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] ax1;
		logic signed [31:0] ay1;
		logic signed [31:0] bx1;
		logic signed [31:0] by1;
		logic signed [31:0] ax2;
		logic signed [31:0] ay2;
		logic signed [31:0] bx2;
		logic signed [31:0] by2;
	} item_t;

	typedef struct packed {
		logic          kind;
		logic          par;
		logic          miss;
		logic [DW-1:0] d;
		logic [MW-1:0] mag_x;
		logic [MW-1:0] mag_y;
		logic          neg_x;
		logic          neg_y;
	} front_t;

	typedef struct packed {
		logic kind;
		logic par;
		logic miss;
		logic neg_x;
		logic neg_y;
	} side_t;

endpackage
`default_nettype wire

// ===== src/slsi_if.sv =====
`default_nettype none
interface slsi_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] first_ax;
	logic signed [31:0] first_ay;
	logic signed [31:0] first_bx;
	logic signed [31:0] first_by;
	logic signed [31:0] second_ax;
	logic signed [31:0] second_ay;
	logic signed [31:0] second_bx;
	logic signed [31:0] second_by;

	modport source (output valid, kind, first_ax, first_ay, first_bx, first_by,
		second_ax, second_ay, second_bx, second_by, input ready);
	modport sink (input valid, kind, first_ax, first_ay, first_bx, first_by,
		second_ax, second_ay, second_bx, second_by, output ready);
endinterface

interface slsi_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [1:0]         status;
	logic signed [31:0] cross_x;
	logic signed [31:0] cross_y;

	modport source (output valid, hit, status, cross_x, cross_y, input ready);
	modport sink (input valid, hit, status, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

// ===== src/segment_line_intersection_unit.sv =====
// Segment and line intersection pipeline.
// Input channel req carries one transaction per pair of lines: kind (0 for
// bounded segments, 1 for infinite lines) and the endpoints of both lines.
// Output channel rsp returns one transaction per input: hit, status
// (intersect, parallel, outside segments, point out of range) and the
// intersection point truncated toward zero, zero when there is no hit.
// Both channels use valid/ready; a transaction moves when both are high.
// The quotient has QB = max(COORD_BITS, 32) + 1 bits; the restoring divider
// produces one quotient bit per stage, behind an eight stage front end of
// cross products and partial products.
// One transaction is accepted per cycle while rsp does not hold the output.
// The whole pipeline advances together: while the output register holds a
// result that rsp does not take, req.ready is low and every stage holds, so
// nothing is dropped or repeated. Bubbles advance whenever the output is free.
// Reset clears all valid bits; the block then accepts at once.
`default_nettype none
module segment_line_intersection_unit #(
	parameter int COORD_BITS = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	slsi_req_if.sink  req,
	slsi_rsp_if.source rsp
);
	import slsi_pkg::*;

	localparam int QB = ((COORD_BITS > 32) ? COORD_BITS : 32) + 1;

	logic   en;
	item_t  item;
	logic   fr_vld;
	front_t fr;

	logic [QB-1:0] q_x, q_y;
	logic          rnz_x, rnz_y, ovf_x, ovf_y;

	side_t sb_s  [QB+1];
	logic  vb_s  [QB+1];

	logic        out_vld_q;
	logic        hit_q;
	logic [1:0]  status_q;
	logic [31:0] cx_q, cy_q;

	assign en        = !out_vld_q || rsp.ready;
	assign req.ready = en;

	assign item.kind = req.kind;
	assign item.ax1  = req.first_ax;
	assign item.ay1  = req.first_ay;
	assign item.bx1  = req.first_bx;
	assign item.by1  = req.first_by;
	assign item.ax2  = req.second_ax;
	assign item.ay2  = req.second_ay;
	assign item.bx2  = req.second_bx;
	assign item.by2  = req.second_by;

	slsi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (req.valid),
		.item    (item),
		.vld_out (fr_vld),
		.res     (fr)
	);

	slsi_div #(.QB(QB)) u_div_x (
		.clk    (clk),
		.en     (en),
		.d      (fr.d),
		.mag    (fr.mag_x),
		.q      (q_x),
		.rem_nz (rnz_x),
		.ovf    (ovf_x)
	);

	slsi_div #(.QB(QB)) u_div_y (
		.clk    (clk),
		.en     (en),
		.d      (fr.d),
		.mag    (fr.mag_y),
		.q      (q_y),
		.rem_nz (rnz_y),
		.ovf    (ovf_y)
	);

	// Flags ride alongside the dividers with the same latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) vb_s[k] <= 1'b0;
		end else if (en) begin
			vb_s[0] <= fr_vld;
			for (int k = 1; k <= QB; k++) vb_s[k] <= vb_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= '{kind: fr.kind, par: fr.par, miss: fr.miss,
				neg_x: fr.neg_x, neg_y: fr.neg_y};
			for (int k = 1; k <= QB; k++) sb_s[k] <= sb_s[k-1];
		end
	end

	side_t         sb;
	logic [QB-1:0] lim;
	logic          oor_x, oor_y;
	logic [QB-1:0] sx, sy;
	logic [1:0]    status_d;

	assign sb  = sb_s[QB];
	assign lim = QB'(1) << (COORD_BITS - 1);

	// The exact value, not the truncated one, decides the range: a nonzero
	// remainder pushes a quotient sitting on the limit just past it.
	assign oor_x = ovf_x || (sb.neg_x ?
		((q_x > lim) || ((q_x == lim) && rnz_x)) :
		((q_x >= lim) || ((q_x == lim - QB'(1)) && rnz_x)));
	assign oor_y = ovf_y || (sb.neg_y ?
		((q_y > lim) || ((q_y == lim) && rnz_y)) :
		((q_y >= lim) || ((q_y == lim - QB'(1)) && rnz_y)));

	assign sx = sb.neg_x ? -q_x : q_x;
	assign sy = sb.neg_y ? -q_y : q_y;

	always_comb begin
		if (sb.par)
			status_d = ST_PARALLEL;
		else if (!sb.kind && sb.miss)
			status_d = ST_MISS;
		else if (sb.kind && (oor_x || oor_y))
			status_d = ST_RANGE;
		else
			status_d = ST_HIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vb_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= status_d;
			hit_q    <= (status_d == ST_HIT);
			cx_q     <= (status_d == ST_HIT) ? sx[31:0] : 32'd0;
			cy_q     <= (status_d == ST_HIT) ? sy[31:0] : 32'd0;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.hit     = hit_q;
	assign rsp.status  = status_q;
	assign rsp.cross_x = cx_q;
	assign rsp.cross_y = cy_q;
endmodule
`default_nettype wire

// ===== src/slsi_front.sv =====
`default_nettype none
module slsi_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vld_in,
	input  wire slsi_pkg::item_t item,
	output logic                 vld_out,
	output slsi_pkg::front_t     res
);
	import slsi_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	// Stage 1: direction and offset vectors.
	logic signed [VW-1:0] v1x_s1, v1y_s1, v2x_s1, v2y_s1, wx_s1, wy_s1;
	logic signed [31:0]   ax_s1, ay_s1;
	logic                 kind_s1;
	// Stage 2: the six products of the three cross products.
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [VW-1:0] v1x_s2, v1y_s2;
	logic signed [31:0]   ax_s2, ay_s2;
	logic                 kind_s2;
	// Stage 3: denominator and both numerators.
	logic signed [CW-1:0] d_s3, n1_s3, n2_s3;
	logic signed [VW-1:0] v1x_s3, v1y_s3;
	logic signed [31:0]   ax_s3, ay_s3;
	logic                 kind_s3;
	// Stage 4: sign normalized so that the denominator is not negative.
	logic [DW-1:0]        d_s4;
	logic signed [CW-1:0] n1_s4, n2_s4;
	logic                 par_s4;
	logic signed [VW-1:0] v1x_s4, v1y_s4;
	logic signed [31:0]   ax_s4, ay_s4;
	logic                 kind_s4;
	// Stage 5: segment test and partial products of d*a and n1*v.
	logic signed [65:0]   pdlo_x_s5, pdhi_x_s5, pdlo_y_s5, pdhi_y_s5;
	logic signed [67:0]   pnlo_x_s5, pnlo_y_s5;
	logic signed [65:0]   pnhi_x_s5, pnhi_y_s5;
	logic [DW-1:0]        d_s5;
	logic                 par_s5, miss_s5, kind_s5;
	// Stage 6: partial products joined.
	logic signed [NW-1:0] da_x_s6, nv_x_s6, da_y_s6, nv_y_s6;
	logic [DW-1:0]        d_s6;
	logic                 par_s6, miss_s6, kind_s6;
	// Stage 7: point numerators.
	logic signed [NW-1:0] num_x_s7, num_y_s7;
	logic [DW-1:0]        d_s7;
	logic                 par_s7, miss_s7, kind_s7;
	// Stage 8: sign and magnitude for the divider.
	front_t               res_s8;

	logic                 d_neg;
	logic signed [CW-1:0] d_pos;
	logic signed [CW-1:0] d_ext;

	assign d_neg = d_s3[CW-1];
	assign d_pos = d_neg ? -d_s3 : d_s3;
	assign d_ext = $signed({1'b0, d_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1x_s1  <= VW'(item.bx1) - VW'(item.ax1);
			v1y_s1  <= VW'(item.by1) - VW'(item.ay1);
			v2x_s1  <= VW'(item.bx2) - VW'(item.ax2);
			v2y_s1  <= VW'(item.by2) - VW'(item.ay2);
			wx_s1   <= VW'(item.ax2) - VW'(item.ax1);
			wy_s1   <= VW'(item.ay2) - VW'(item.ay1);
			ax_s1   <= item.ax1;
			ay_s1   <= item.ay1;
			kind_s1 <= item.kind;

			p0_s2   <= v1x_s1 * v2y_s1;
			p1_s2   <= v1y_s1 * v2x_s1;
			p2_s2   <= wx_s1 * v2y_s1;
			p3_s2   <= wy_s1 * v2x_s1;
			p4_s2   <= wx_s1 * v1y_s1;
			p5_s2   <= wy_s1 * v1x_s1;
			v1x_s2  <= v1x_s1;
			v1y_s2  <= v1y_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			kind_s2 <= kind_s1;

			d_s3    <= CW'(p0_s2) - CW'(p1_s2);
			n1_s3   <= CW'(p2_s2) - CW'(p3_s2);
			n2_s3   <= CW'(p4_s2) - CW'(p5_s2);
			v1x_s3  <= v1x_s2;
			v1y_s3  <= v1y_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			kind_s3 <= kind_s2;

			d_s4    <= d_pos[DW-1:0];
			n1_s4   <= d_neg ? -n1_s3 : n1_s3;
			n2_s4   <= d_neg ? -n2_s3 : n2_s3;
			par_s4  <= (d_s3 == '0);
			v1x_s4  <= v1x_s3;
			v1y_s4  <= v1y_s3;
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
			kind_s4 <= kind_s3;

			miss_s5   <= n1_s4[CW-1] || (n1_s4 > d_ext) || n2_s4[CW-1] || (n2_s4 > d_ext);
			pdlo_x_s5 <= $signed({1'b0, d_s4[32:0]}) * ax_s4;
			pdhi_x_s5 <= $signed({1'b0, d_s4[65:33]}) * ax_s4;
			pdlo_y_s5 <= $signed({1'b0, d_s4[32:0]}) * ay_s4;
			pdhi_y_s5 <= $signed({1'b0, d_s4[65:33]}) * ay_s4;
			pnlo_x_s5 <= $signed({1'b0, n1_s4[33:0]}) * v1x_s4;
			pnhi_x_s5 <= $signed(n1_s4[66:34]) * v1x_s4;
			pnlo_y_s5 <= $signed({1'b0, n1_s4[33:0]}) * v1y_s4;
			pnhi_y_s5 <= $signed(n1_s4[66:34]) * v1y_s4;
			d_s5      <= d_s4;
			par_s5    <= par_s4;
			kind_s5   <= kind_s4;

			da_x_s6 <= (NW'(pdhi_x_s5) <<< 33) + NW'(pdlo_x_s5);
			nv_x_s6 <= (NW'(pnhi_x_s5) <<< 34) + NW'(pnlo_x_s5);
			da_y_s6 <= (NW'(pdhi_y_s5) <<< 33) + NW'(pdlo_y_s5);
			nv_y_s6 <= (NW'(pnhi_y_s5) <<< 34) + NW'(pnlo_y_s5);
			d_s6    <= d_s5;
			par_s6  <= par_s5;
			miss_s6 <= miss_s5;
			kind_s6 <= kind_s5;

			num_x_s7 <= da_x_s6 + nv_x_s6;
			num_y_s7 <= da_y_s6 + nv_y_s6;
			d_s7     <= d_s6;
			par_s7   <= par_s6;
			miss_s7  <= miss_s6;
			kind_s7  <= kind_s6;

			res_s8.neg_x <= num_x_s7[NW-1];
			res_s8.neg_y <= num_y_s7[NW-1];
			res_s8.mag_x <= num_x_s7[NW-1] ? MW'(-num_x_s7) : MW'(num_x_s7);
			res_s8.mag_y <= num_y_s7[NW-1] ? MW'(-num_y_s7) : MW'(num_y_s7);
			res_s8.d     <= d_s7;
			res_s8.par   <= par_s7;
			res_s8.miss  <= miss_s7;
			res_s8.kind  <= kind_s7;
		end
	end

	assign vld_out = vld_s8;
	assign res     = res_s8;
endmodule
`default_nettype wire

// ===== src/slsi_div.sv =====
`default_nettype none
module slsi_div #(
	parameter int QB = 33
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [slsi_pkg::DW-1:0] d,
	input  wire logic [slsi_pkg::MW-1:0] mag,
	output logic [QB-1:0]               q,
	output logic                        rem_nz,
	output logic                        ovf
);
	import slsi_pkg::*;

	logic [DW-1:0] rem_s  [QB+1];
	logic [DW-1:0] d_s    [QB+1];
	logic [QB-1:0] lowb_s [QB+1];
	logic [QB-1:0] q_s    [QB+1];
	logic          ovf_s  [QB+1];

	logic [MW-1:0] top;
	assign top = mag >> QB;

	// The bits above the quotient window must already be below the divisor,
	// otherwise the quotient does not fit and the point is out of range.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= top[DW-1:0];
			ovf_s[0]  <= (top >= MW'(d));
			lowb_s[0] <= mag[QB-1:0];
			q_s[0]    <= '0;
			d_s[0]    <= d;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;

		assign t    = {rem_s[k-1], lowb_s[k-1][QB-k]};
		assign diff = t - {1'b0, d_s[k-1]};
		assign ge   = (t >= {1'b0, d_s[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
				q_s[k]    <= {q_s[k-1][QB-2:0], ge};
				lowb_s[k] <= lowb_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				d_s[k]    <= d_s[k-1];
			end
		end
	end

	assign q      = q_s[QB];
	assign rem_nz = |rem_s[QB];
	assign ovf    = ovf_s[QB];
endmodule
`default_nettype wire
